>>> sv/aifp_pkg.sv
`timescale 1ns / 1ps
// Package for the ASCII integer field parser: result beat type, status codes,
// character codes and register indexes. No dependencies.
package aifp_pkg;

    localparam int MAX_TOKEN = 7;
    localparam int WEFF_W    = 9;

    localparam logic [2:0] ST_LINE_END  = 3'd0;
    localparam logic [2:0] ST_COUNT_HIT = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd3;
    localparam logic [2:0] ST_BLANK     = 3'd4;
    localparam logic [2:0] ST_EOF       = 3'd5;

    localparam logic [1:0] PH_SIGN   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic CFG_SKIP   = 1'b0;
    localparam logic CFG_WANTED = 1'b1;

    typedef struct packed {
        logic              kind;
        logic signed [20:0] value;
        logic [5:0]        value_index;
        logic [6:0]        count;
        logic [2:0]        status;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

>>> sv/ascii_integer_field_parser.sv
`timescale 1ns / 1ps
// ASCII integer field parser, top level. Depends on aifp_pkg, aifp_core, aifp_fifo.
// An input beat is held in the input register, then parsed into the four-entry
// result queue. Throughput: one character per cycle while the queue has room
// (in_stall low); the single output port limits it to one result beat per cycle.
// Reset: asynchronous, clears line state; skip_columns = 0, wanted_count = 64.
module ascii_integer_field_parser
#(
    parameter int LINE_LEN   = 256,
    parameter int MAX_VALUES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [7:0]         char_code,
    input  logic               last_in_line,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic signed [20:0] value,
    output logic [5:0]         value_index,
    output logic [6:0]         count,
    output logic [2:0]         status,
    output logic               last
);

    logic       stage_valid_reg, stage_valid_next;
    logic       command_reg;
    logic [7:0] char_reg;
    logic       lil_reg;
    logic       room, not_empty, step, accept, pop;
    aifp_pkg::push_t   push;
    aifp_pkg::result_t head;

    assign cfg_ready = 1'b1;
    assign in_stall  = stage_valid_reg && !room;
    assign accept    = in_valid && !in_stall;
    assign step      = stage_valid_reg && room;
    assign out_valid = not_empty;
    assign pop       = not_empty && !out_stall;

    assign kind        = head.kind;
    assign value       = head.value;
    assign value_index = head.value_index;
    assign count       = head.count;
    assign status      = head.status;
    assign last        = head.last;

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (step)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            command_reg <= command;
            char_reg    <= char_code;
            lil_reg     <= last_in_line;
        end
    end

    aifp_core
    #(
        .LINE_LEN   (LINE_LEN),
        .MAX_VALUES (MAX_VALUES)
    )
    u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step         (step),
        .command      (command_reg),
        .char_code    (char_reg),
        .last_in_line (lil_reg),
        .push         (push)
    );

    aifp_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .room      (room),
        .not_empty (not_empty),
        .head      (head)
    );

endmodule

>>> sv/aifp_fifo.sv
`timescale 1ns / 1ps
// Four-entry result queue; takes up to two beats per cycle, gives one.
// Depends on aifp_pkg.
module aifp_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  aifp_pkg::push_t  push,
    input  logic             pop,
    output logic             room,
    output logic             not_empty,
    output aifp_pkg::result_t head
);

    aifp_pkg::result_t entry_reg [4];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] fill_reg, fill_next;
    logic [1:0] tail_plus1;

    assign tail_plus1 = tail_reg + 2'd1;
    assign room       = fill_reg <= 3'd2;
    assign not_empty  = fill_reg != 3'd0;
    assign head       = entry_reg[head_reg];

    always_comb
    begin
        head_next = pop ? head_reg + 2'd1 : head_reg;
        tail_next = tail_reg + push.num;
        fill_next = fill_reg + {1'b0, push.num} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            entry_reg[tail_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            entry_reg[tail_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

endmodule

>>> sv/aifp_core.sv
`timescale 1ns / 1ps
// Per-character tokenizer and atoi conversion with line state and config regs.
// Depends on aifp_pkg.
module aifp_core
#(
    parameter int LINE_LEN   = 256,
    parameter int MAX_VALUES = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_data,
    input  logic            step,
    input  logic            command,
    input  logic [7:0]      char_code,
    input  logic            last_in_line,
    output aifp_pkg::push_t push
);

    localparam int COL_W = $clog2(LINE_LEN);
    localparam int CMP_W = (COL_W > 8) ? COL_W : 8;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_LEN - 1);
    localparam logic [aifp_pkg::WEFF_W-1:0] MAXV = aifp_pkg::WEFF_W'(MAX_VALUES);

    logic [7:0]       skip_reg;
    logic [6:0]       wanted_reg;

    logic [COL_W-1:0] column_reg, column_next;
    logic [2:0]       toklen_reg, toklen_next;
    logic [19:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic [1:0]       phase_reg, phase_next;
    logic [6:0]       emitted_reg, emitted_next;
    logic             seen_reg, seen_next;
    logic             stopped_reg, stopped_next;
    logic [2:0]       lstat_reg, lstat_next;

    logic [aifp_pkg::WEFF_W-1:0] weff;
    logic                        in_window;
    logic                        is_digit, is_sign, is_delim, is_slash;
    logic [3:0]                  digit;
    logic [2:0]                  toklen_inc;
    logic [20:0]                 acc_ext;
    logic [2:0]                  summ_status;
    aifp_pkg::result_t           token_res, summ_res;
    logic                        emitted_tok;

    assign weff = ({2'b00, wanted_reg} > MAXV) ? MAXV : {2'b00, wanted_reg};
    assign in_window = (CMP_W'(column_reg) >= CMP_W'(skip_reg)) && (column_reg != COL_LAST);
    assign is_digit = (char_code >= aifp_pkg::CH_ZERO) && (char_code <= aifp_pkg::CH_NINE);
    assign is_sign  = (char_code == aifp_pkg::CH_PLUS) || (char_code == aifp_pkg::CH_MINUS);
    assign is_delim = (char_code == aifp_pkg::CH_SPACE) || (char_code == aifp_pkg::CH_COMMA)
                   || (char_code == aifp_pkg::CH_TAB) || (char_code == aifp_pkg::CH_NEWLINE);
    assign is_slash = char_code == aifp_pkg::CH_SLASH;
    assign digit      = char_code[3:0];
    assign toklen_inc = toklen_reg + 3'd1;
    assign acc_ext    = {1'b0, acc_reg};

    always_comb
    begin
        column_next  = column_reg;
        toklen_next  = toklen_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        phase_next   = phase_reg;
        emitted_next = emitted_reg;
        seen_next    = seen_reg;
        stopped_next = stopped_reg;
        lstat_next   = lstat_reg;
        emitted_tok  = 1'b0;
        summ_status  = aifp_pkg::ST_LINE_END;

        token_res.kind        = aifp_pkg::KIND_VALUE;
        token_res.value       = neg_reg ? -acc_ext : acc_ext;
        token_res.value_index = emitted_reg[5:0];
        token_res.count       = '0;
        token_res.status      = aifp_pkg::ST_LINE_END;
        token_res.last        = 1'b0;

        if (command == aifp_pkg::CMD_EOF)
        begin
            column_next  = '0;
            toklen_next  = '0;
            acc_next     = '0;
            neg_next     = 1'b0;
            phase_next   = aifp_pkg::PH_SIGN;
            emitted_next = '0;
            seen_next    = 1'b0;
            stopped_next = 1'b0;
            lstat_next   = aifp_pkg::ST_LINE_END;
            summ_status  = aifp_pkg::ST_EOF;
        end
        else
        begin
            if (!stopped_reg)
            begin
                if (weff == '0)
                begin
                    stopped_next = 1'b1;
                    lstat_next   = aifp_pkg::ST_COUNT_HIT;
                end
                else if (in_window)
                begin
                    if (char_code != aifp_pkg::CH_SPACE)
                    begin
                        seen_next = 1'b1;
                    end
                    if (is_digit || is_sign)
                    begin
                        toklen_next = toklen_inc;
                        if (toklen_inc >= 3'(aifp_pkg::MAX_TOKEN))
                        begin
                            stopped_next = 1'b1;
                            lstat_next   = aifp_pkg::ST_TOO_LONG;
                        end
                        else if (phase_reg == aifp_pkg::PH_SIGN)
                        begin
                            if (is_digit)
                            begin
                                acc_next = {16'd0, digit};
                            end
                            else
                            begin
                                neg_next = char_code == aifp_pkg::CH_MINUS;
                            end
                            phase_next = aifp_pkg::PH_DIGITS;
                        end
                        else if (phase_reg == aifp_pkg::PH_DIGITS)
                        begin
                            if (is_digit)
                            begin
                                acc_next = (acc_reg << 3) + (acc_reg << 1) + {16'd0, digit};
                            end
                            else
                            begin
                                phase_next = aifp_pkg::PH_DONE;
                            end
                        end
                    end
                    else if (is_delim || is_slash)
                    begin
                        if (toklen_reg != 3'd0)
                        begin
                            emitted_tok  = 1'b1;
                            emitted_next = emitted_reg + 7'd1;
                            toklen_next  = '0;
                            acc_next     = '0;
                            neg_next     = 1'b0;
                            phase_next   = aifp_pkg::PH_SIGN;
                            if ({2'b00, emitted_next} >= weff)
                            begin
                                stopped_next = 1'b1;
                                lstat_next   = aifp_pkg::ST_COUNT_HIT;
                            end
                        end
                        if (is_slash && !stopped_next)
                        begin
                            stopped_next = 1'b1;
                            lstat_next   = aifp_pkg::ST_LINE_END;
                        end
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                        lstat_next   = aifp_pkg::ST_BAD_CHAR;
                    end
                end
            end
            if (column_reg != COL_LAST)
            begin
                column_next = column_reg + COL_W'(1);
            end
            if (last_in_line)
            begin
                if (stopped_next)
                begin
                    summ_status = lstat_next;
                end
                else if (!seen_next)
                begin
                    summ_status = aifp_pkg::ST_BLANK;
                end
                else
                begin
                    summ_status = aifp_pkg::ST_LINE_END;
                end
                column_next  = '0;
                toklen_next  = '0;
                acc_next     = '0;
                neg_next     = 1'b0;
                phase_next   = aifp_pkg::PH_SIGN;
                emitted_next = '0;
                seen_next    = 1'b0;
                stopped_next = 1'b0;
                lstat_next   = aifp_pkg::ST_LINE_END;
            end
        end

        summ_res.kind        = aifp_pkg::KIND_SUMMARY;
        summ_res.value       = '0;
        summ_res.value_index = '0;
        summ_res.count       = (summ_status == aifp_pkg::ST_BLANK
                               || command == aifp_pkg::CMD_EOF)
                               ? 7'd0 : emitted_reg + {6'd0, emitted_tok};
        summ_res.status      = summ_status;
        summ_res.last        = 1'b1;

        push.first  = emitted_tok ? token_res : summ_res;
        push.second = summ_res;
        if (!step)
        begin
            push.num = 2'd0;
        end
        else if (command == aifp_pkg::CMD_EOF)
        begin
            push.num = 2'd1;
        end
        else
        begin
            push.num = {1'b0, emitted_tok} + {1'b0, last_in_line};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg    <= 8'd0;
            wanted_reg  <= 7'd64;
            column_reg  <= '0;
            toklen_reg  <= '0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            phase_reg   <= aifp_pkg::PH_SIGN;
            emitted_reg <= '0;
            seen_reg    <= 1'b0;
            stopped_reg <= 1'b0;
            lstat_reg   <= aifp_pkg::ST_LINE_END;
        end
        else
        begin
            if (cfg_we && cfg_index == aifp_pkg::CFG_SKIP)
            begin
                skip_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == aifp_pkg::CFG_WANTED)
            begin
                wanted_reg <= cfg_data[6:0];
            end
            if (step)
            begin
                column_reg  <= column_next;
                toklen_reg  <= toklen_next;
                acc_reg     <= acc_next;
                neg_reg     <= neg_next;
                phase_reg   <= phase_next;
                emitted_reg <= emitted_next;
                seen_reg    <= seen_next;
                stopped_reg <= stopped_next;
                lstat_reg   <= lstat_next;
            end
        end
    end

endmodule
